// ----- design/chfr_pkg.sv -----
package chfr_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS   = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int HUM_W       = 7;

    // Counts below this value (x above 4.0) give zero humidity directly.
    localparam logic [63:0] MIN_COUNT = 64'd1554;
    localparam logic [31:0] HUM_MAX   = 32'd99;

    // Dividend: 6216.006216 scaled by 2^FRAC_BITS, truncated.
    localparam logic [63:0] NUMER = (64'd6216006216 << FRAC_BITS) / 64'd1000000;

    // Cubic coefficients with FRAC_BITS fraction bits (magnitudes).
    localparam logic [63:0] COEF3 = ((64'd34656 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [63:0] COEF2 = 64'd10732 << FRAC_BITS;
    localparam logic [63:0] COEF1 = 64'd10457 << FRAC_BITS;
    localparam logic [63:0] COEF0 = ((64'd32459 << FRAC_BITS) + 64'd5) / 64'd10;

    localparam int NUM_W = $clog2(NUMER + 64'd1);
    // Quotient width covers the largest x reached for a count at MIN_COUNT.
    localparam int X_W   = $clog2((NUMER / MIN_COUNT) + 64'd1);
    localparam int C3_W  = $clog2(COEF3 + 64'd1);
    localparam int C2_W  = $clog2(COEF2 + 64'd1);
    localparam int C1_W  = $clog2(COEF1 + 64'd1);
    localparam int C0_W  = $clog2(COEF0 + 64'd1);

    // Horner intermediate widths, all exact.
    localparam int P3_W  = C3_W + X_W;
    localparam int T1_W  = ((P3_W > C2_W + FRAC_BITS) ? P3_W : C2_W + FRAC_BITS) + 1;
    localparam int TX1_W = T1_W + X_W;
    localparam int T2_W  = ((TX1_W > C1_W + 2 * FRAC_BITS) ?
                            TX1_W : C1_W + 2 * FRAC_BITS) + 1;
    localparam int MT_W  = T2_W;
    localparam int MP_W  = MT_W + X_W;
    localparam int V_W   = ((MP_W > C0_W + 3 * FRAC_BITS) ?
                            MP_W : C0_W + 3 * FRAC_BITS) + 1;
    localparam int IP_W  = V_W - 1 - 4 * FRAC_BITS;

    // Wide multiplier chunking.
    localparam int CH_W  = 24;
    localparam int N_CH  = (MT_W + CH_W - 1) / CH_W;
    localparam int TOP_W = MT_W - (N_CH - 1) * CH_W;

    localparam logic [NUM_W-1:0]       NUM_V    = NUMER[NUM_W-1:0];
    localparam logic [63:0]            NUM_SHR  = NUMER >> X_W;
    localparam logic [COUNT_WIDTH-1:0] DIV_INIT = NUM_SHR[COUNT_WIDTH-1:0];

    localparam logic [C3_W-1:0] C3_V = COEF3[C3_W-1:0];
    localparam logic [C2_W-1:0] C2_V = COEF2[C2_W-1:0];
    localparam logic [C1_W-1:0] C1_V = COEF1[C1_W-1:0];
    localparam logic [C0_W-1:0] C0_V = COEF0[C0_W-1:0];

    // Coefficients aligned to the fraction point of the Horner step that uses them.
    localparam logic [T1_W-1:0] K2_T1 =
        {{(T1_W - C2_W - FRAC_BITS){1'b0}}, C2_V, {FRAC_BITS{1'b0}}};
    localparam logic [T2_W-1:0] K1_T2 =
        {{(T2_W - C1_W - 2 * FRAC_BITS){1'b0}}, C1_V, {(2 * FRAC_BITS){1'b0}}};
    localparam logic [V_W-1:0]  K0_V  =
        {{(V_W - C0_W - 3 * FRAC_BITS){1'b0}}, C0_V, {(3 * FRAC_BITS){1'b0}}};

    localparam logic [HUM_W-1:0] HUM_MAX_V = HUM_MAX[HUM_W-1:0];
    localparam logic [IP_W-1:0]  HUM_CAP   = {{(IP_W - HUM_W){1'b0}}, HUM_MAX_V};

    // Per-item status that rides along the pipeline.
    typedef struct packed {
        logic force_zero;
        logic count_zero;
    } t_tag;

endpackage

// ----- design/chfr_in_if.sv -----
interface chfr_in_if;
    logic                             valid;
    logic                             ready;
    logic [chfr_pkg::COUNT_WIDTH-1:0] pulse_count;

    modport source (output valid, output pulse_count, input ready);
    modport sink   (input valid, input pulse_count, output ready);
endinterface

// ----- design/chfr_out_if.sv -----
interface chfr_out_if;
    logic                       valid;
    logic                       ready;
    logic [chfr_pkg::HUM_W-1:0] humidity;
    logic                       count_zero;

    modport source (output valid, output humidity, output count_zero, input ready);
    modport sink   (input valid, input humidity, input count_zero, output ready);
endinterface

// ----- design/chfr_div.sv -----
module chfr_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [chfr_pkg::COUNT_WIDTH-1:0] i_count,
    input  chfr_pkg::t_tag                   i_tag,
    output logic                             o_vld,
    output logic [chfr_pkg::X_W-1:0]         o_x,
    output chfr_pkg::t_tag                   o_tag
);

    typedef struct packed {
        logic [chfr_pkg::COUNT_WIDTH-1:0] rem;
        logic                             qbit;
    } t_dstep;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    function automatic t_dstep div_step(
        input logic [chfr_pkg::COUNT_WIDTH-1:0] rem,
        input logic [chfr_pkg::COUNT_WIDTH-1:0] d,
        input logic                             nbit
    );
        logic [chfr_pkg::COUNT_WIDTH:0] trial;
        logic [chfr_pkg::COUNT_WIDTH:0] diff;
        t_dstep                         res;
        trial = {rem, nbit};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            res.rem  = diff[chfr_pkg::COUNT_WIDTH-1:0];
            res.qbit = 1'b1;
        end else begin
            res.rem  = trial[chfr_pkg::COUNT_WIDTH-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

    logic [chfr_pkg::X_W-1:0]         r_vld;
    logic [chfr_pkg::COUNT_WIDTH-1:0] r_rem [chfr_pkg::X_W-1];
    logic [chfr_pkg::COUNT_WIDTH-1:0] r_d   [chfr_pkg::X_W-1];
    logic [chfr_pkg::X_W-1:0]         r_q   [chfr_pkg::X_W];
    chfr_pkg::t_tag                   r_tag [chfr_pkg::X_W];
    t_dstep                           n_step [chfr_pkg::X_W];

    always_comb begin
        n_step[0] = div_step(chfr_pkg::DIV_INIT, i_count,
                             chfr_pkg::NUM_V[chfr_pkg::X_W-1]);
        for (int k = 1; k < chfr_pkg::X_W; k++) begin
            n_step[k] = div_step(r_rem[k-1], r_d[k-1],
                                 chfr_pkg::NUM_V[chfr_pkg::X_W-1-k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[chfr_pkg::X_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_step[0].rem;
            r_d[0]   <= i_count;
            r_q[0]   <= {{(chfr_pkg::X_W-1){1'b0}}, n_step[0].qbit};
            r_tag[0] <= i_tag;
            for (int k = 1; k < chfr_pkg::X_W; k++) begin
                r_q[k]   <= {r_q[k-1][chfr_pkg::X_W-2:0], n_step[k].qbit};
                r_tag[k] <= r_tag[k-1];
            end
            for (int k = 1; k < chfr_pkg::X_W - 1; k++) begin
                r_rem[k] <= n_step[k].rem;
                r_d[k]   <= r_d[k-1];
            end
        end
    end

    assign o_vld = r_vld[chfr_pkg::X_W-1];
    assign o_x   = r_q[chfr_pkg::X_W-1];
    assign o_tag = r_tag[chfr_pkg::X_W-1];

endmodule

// ----- design/chfr_mul.sv -----
module chfr_mul (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [chfr_pkg::MT_W-1:0]   i_t,
    input  logic        [chfr_pkg::X_W-1:0]    i_x,
    output logic signed [chfr_pkg::MP_W-1:0]   o_p
);

    // Two stages: chunk products, then their aligned sum.
    logic signed [chfr_pkg::MP_W-1:0] r_pp [chfr_pkg::N_CH];
    logic signed [chfr_pkg::MP_W-1:0] n_pp [chfr_pkg::N_CH];
    logic signed [chfr_pkg::MP_W-1:0] r_p;
    logic signed [chfr_pkg::MP_W-1:0] n_p;
    logic signed [chfr_pkg::TOP_W+chfr_pkg::X_W:0] w_ht;
    logic signed [chfr_pkg::TOP_W+chfr_pkg::X_W:0] w_hx;
    logic signed [chfr_pkg::TOP_W+chfr_pkg::X_W:0] w_hi;

    always_comb begin
        for (int c = 0; c < chfr_pkg::N_CH - 1; c++) begin
            n_pp[c] = {{(chfr_pkg::MP_W - chfr_pkg::CH_W - chfr_pkg::X_W){1'b0}},
                       ({{chfr_pkg::CH_W{1'b0}}, i_x} *
                        {{chfr_pkg::X_W{1'b0}}, i_t[c*chfr_pkg::CH_W +: chfr_pkg::CH_W]})};
        end
        // The top chunk carries the sign of the operand.
        w_ht = {{(chfr_pkg::X_W+1){i_t[chfr_pkg::MT_W-1]}},
                i_t[chfr_pkg::MT_W-1 -: chfr_pkg::TOP_W]};
        w_hx = {{(chfr_pkg::TOP_W+1){1'b0}}, i_x};
        w_hi = w_ht * w_hx;
        n_pp[chfr_pkg::N_CH-1] =
            {{(chfr_pkg::MP_W - chfr_pkg::TOP_W - chfr_pkg::X_W - 1)
              {w_hi[chfr_pkg::TOP_W+chfr_pkg::X_W]}}, w_hi};
    end

    always_comb begin
        n_p = '0;
        for (int c = 0; c < chfr_pkg::N_CH; c++) begin
            n_p = n_p + (r_pp[c] <<< (c * chfr_pkg::CH_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < chfr_pkg::N_CH; c++) begin
                r_pp[c] <= n_pp[c];
            end
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ----- design/chfr_poly.sv -----
module chfr_poly (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [chfr_pkg::X_W-1:0]   i_x,
    input  chfr_pkg::t_tag             i_tag,
    output logic                       o_vld,
    output logic [chfr_pkg::HUM_W-1:0] o_humidity,
    output chfr_pkg::t_tag             o_tag
);

    localparam int ST = 9;

    logic [ST-1:0]                      r_vld;
    chfr_pkg::t_tag                     r_tag [ST];
    logic [chfr_pkg::X_W-1:0]           r_x1, r_x2, r_x3, r_x4, r_x5;
    logic [chfr_pkg::P3_W-1:0]          r_p3;
    logic signed [chfr_pkg::T1_W-1:0]   r_t1;
    logic signed [chfr_pkg::MT_W-1:0]   r_t2;
    logic signed [chfr_pkg::MT_W-1:0]   w_ta;
    logic signed [chfr_pkg::MP_W-1:0]   w_pa;
    logic signed [chfr_pkg::MP_W-1:0]   w_pb;
    logic signed [chfr_pkg::V_W-1:0]    r_v;
    logic [chfr_pkg::IP_W-1:0]          w_ip;
    logic [chfr_pkg::HUM_W-1:0]         r_hum;
    logic [chfr_pkg::HUM_W-1:0]         n_hum;

    assign w_ta = {{(chfr_pkg::MT_W - chfr_pkg::T1_W){r_t1[chfr_pkg::T1_W-1]}}, r_t1};

    // (C2 - C3 x) x
    chfr_mul u_mul_a (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_t   (w_ta),
        .i_x   (r_x2),
        .o_p   (w_pa)
    );

    // ((C2 - C3 x) x - C1) x
    chfr_mul u_mul_b (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_t   (r_t2),
        .i_x   (r_x5),
        .o_p   (w_pb)
    );

    // Integer part of the cubic; a negative value clamps to zero.
    assign w_ip = r_v[chfr_pkg::V_W-2 : 4*chfr_pkg::FRAC_BITS];

    always_comb begin
        if (r_tag[7].force_zero || r_v[chfr_pkg::V_W-1]) begin
            n_hum = '0;
        end else if (w_ip > chfr_pkg::HUM_CAP) begin
            n_hum = chfr_pkg::HUM_MAX_V;
        end else begin
            n_hum = w_ip[chfr_pkg::HUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ST-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < ST; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            r_x1  <= i_x;
            r_p3  <= {{chfr_pkg::X_W{1'b0}}, chfr_pkg::C3_V} *
                     {{chfr_pkg::C3_W{1'b0}}, i_x};
            r_x2  <= r_x1;
            r_t1  <= chfr_pkg::K2_T1 -
                     {{(chfr_pkg::T1_W - chfr_pkg::P3_W){1'b0}}, r_p3};
            r_x3  <= r_x2;
            r_x4  <= r_x3;
            r_t2  <= w_pa[chfr_pkg::MT_W-1:0] - chfr_pkg::K1_T2;
            r_x5  <= r_x4;
            r_v   <= {{(chfr_pkg::V_W - chfr_pkg::MP_W){w_pb[chfr_pkg::MP_W-1]}}, w_pb} +
                     chfr_pkg::K0_V;
            r_hum <= n_hum;
        end
    end

    assign o_vld      = r_vld[ST-1];
    assign o_humidity = r_hum;
    assign o_tag      = r_tag[ST-1];

endmodule

// ----- design/capacitive_humidity_freq_to_rh_core.sv -----
// An accepted input beat passes through the pipelined division, one quotient
// bit per stage, and then the cubic evaluation and clamping stages before it
// leaves as an output beat.
// Throughput: one beat per cycle; the whole pipeline holds while the output waits.
// Reset: synchronous, active low; clears the stage valid bits only, so the
// block accepts a beat in the first cycle after reset.
module capacitive_humidity_freq_to_rh_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chfr_in_if.sink   i_in,
    chfr_out_if.source o_out
);

    // The pipeline advances as a whole. It moves whenever the final stage is
    // empty or its beat is being taken, so bubbles drain and a stall freezes
    // every stage together, which keeps each beat and its valid bit aligned.
    logic                             w_en;
    chfr_pkg::t_tag                   w_tag_in;
    logic                             w_vld_dv;
    logic [chfr_pkg::X_W-1:0]         w_x;
    chfr_pkg::t_tag                   w_tag_dv;
    logic                             w_vld_out;
    logic [chfr_pkg::HUM_W-1:0]       w_hum;
    chfr_pkg::t_tag                   w_tag_out;

    assign w_en       = !w_vld_out || o_out.ready;
    assign i_in.ready = w_en;

    // A zero count is flagged. Any count below the minimum, zero included,
    // gives zero humidity no matter what the divider and polynomial produce,
    // so their result for those counts is never used.
    assign w_tag_in.count_zero = (i_in.pulse_count == '0);
    assign w_tag_in.force_zero =
        ({{(64 - chfr_pkg::COUNT_WIDTH){1'b0}}, i_in.pulse_count} < chfr_pkg::MIN_COUNT);

    // x = NUMER / count with FRAC_BITS fraction bits, one restoring step per stage.
    chfr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_count (i_in.pulse_count),
        .i_tag   (w_tag_in),
        .o_vld   (w_vld_dv),
        .o_x     (w_x),
        .o_tag   (w_tag_dv)
    );

    // Cubic in Horner form with exact products, then truncation and clamping
    // to 0..99. Its last stage is the output register.
    chfr_poly u_poly (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_vld      (w_vld_dv),
        .i_x        (w_x),
        .i_tag      (w_tag_dv),
        .o_vld      (w_vld_out),
        .o_humidity (w_hum),
        .o_tag      (w_tag_out)
    );

    assign o_out.valid      = w_vld_out;
    assign o_out.humidity   = w_hum;
    assign o_out.count_zero = w_tag_out.count_zero;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    // The fixed-point constants are rebuilt here from their decimal definitions,
    // so a bad constant in the package shows up as a mismatch. Every term is
    // held at 128 bits. The widest product, C3 * x^3 with x near 2^18, needs
    // about 82 bits, so no term can overflow.
    localparam int                      FB        = chfr_pkg::FRAC_BITS;
    localparam logic [127:0]            X_NUMER   = (128'd6216006216 << FB) / 128'd1000000;
    localparam logic [127:0]            K3        = ((128'd34656 << FB) + 128'd5) / 128'd10;
    localparam logic [127:0]            K2        = 128'd10732 << FB;
    localparam logic [127:0]            K1        = 128'd10457 << FB;
    localparam logic [127:0]            K0        = ((128'd32459 << FB) + 128'd5) / 128'd10;
    localparam logic [chfr_pkg::COUNT_WIDTH-1:0] LOW_COUNT = 16'd1554;
    localparam logic [chfr_pkg::HUM_W-1:0]       RH_TOP    = 7'd99;

    localparam int RANDOM_COUNTS = 1450;
    // The drain period is longer than the pipeline, with some margin.
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef logic [chfr_pkg::COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        logic [chfr_pkg::HUM_W-1:0] humidity;
        logic                       count_zero;
    } t_reading;

    typedef struct {
        t_count   count;
        t_reading rd;
    } t_pending;

    // The scoreboard keeps the readings that are still due, oldest first. Each
    // reading is worked out when its count beat is accepted. Each output beat
    // is compared against the oldest reading in the queue.
    class rh_scoreboard;
        t_pending due_q[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Linearizes one count: zero humidity below the cutoff (a zero count is flagged),
        // else x = NUMER / count and the cubic with 4F fraction bits, truncated and clamped to 0..99.
        function t_reading rh_from_count(t_count count);
            logic [127:0] x;
            logic [127:0] pos;
            logic [127:0] neg;
            logic [127:0] whole;
            t_reading     r;
            r = '0;
            if (count == '0) begin
                r.count_zero = 1'b1;
            end else if (count >= LOW_COUNT) begin
                x   = X_NUMER / {112'd0, count};
                pos = ((K2 * x * x) << FB) + (K0 << (3 * FB));
                neg = (K3 * x * x * x) + ((K1 * x) << (2 * FB));
                if (pos > neg) begin
                    whole = (pos - neg) >> (4 * FB);
                    r.humidity = (whole > 128'd99) ? RH_TOP
                                                   : whole[chfr_pkg::HUM_W-1:0];
                end
            end
            return r;
        endfunction

        function void note_count(t_count count);
            t_pending p;
            p.count = count;
            p.rd    = rh_from_count(count);
            due_q.push_back(p);
        endfunction

        function void check_reading(t_reading got);
            t_pending p;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb_top: output beat with nothing due: %s%0d count_zero=%0b",
                             "humidity=", got.humidity, got.count_zero);
                return;
            end
            p = due_q.pop_front();
            if (got.humidity !== p.rd.humidity || got.count_zero !== p.rd.count_zero) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb_top: count %0d: expected humidity=%0d count_zero=%0b, %s",
                             p.count, p.rd.humidity, p.rd.count_zero,
                             $sformatf("got humidity=%0d count_zero=%0b",
                                       got.humidity, got.count_zero));
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    chfr_in_if  in_if ();
    chfr_out_if out_if ();

    capacitive_humidity_freq_to_rh_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    rh_scoreboard sb;
    int unsigned  cycles;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Idle lengths are mostly zero or short. A small share runs long
    // enough to let the pipeline fill up behind a stalled output.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random counts are weighted toward the region where the cubic is neither
    // deep negative nor far above 99. That region is roughly 4000 to 11000
    // pulses, and the curve crosses 0 and 99 several times there. The rest
    // covers the low-count cutoff, the saturated high end and the full range.
    function automatic t_count pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return t_count'($urandom_range(4000, 11000));
        if (r < 55)
            return t_count'($urandom_range(1554, 4000));
        if (r < 65)
            return t_count'($urandom_range(11000, 65535));
        if (r < 72)
            return t_count'($urandom_range(0, 1553));
        if (r < 80) begin
            case ($urandom_range(0, 5))
                0: return t_count'(0);
                1: return t_count'(1);
                2: return t_count'(1553);
                3: return t_count'(1554);
                4: return t_count'(1555);
                default: return t_count'(65535);
            endcase
        end
        return t_count'($urandom());
    endfunction

    // Sends one count beat after an optional idle gap. valid is raised at a
    // rising edge and held until an edge where ready is also high. valid stays
    // high into the next beat when no gap follows, so back-to-back beats occur.
    task automatic send_count(t_count count, int gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.pulse_count <= count;
        do
            @(posedge i_clk);
        while (!in_if.ready);
    endtask

    // Input and output monitor. The handshake is sampled at the rising edge,
    // before any driver updates from that edge take effect.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_count(in_if.pulse_count);
            if (out_if.valid && out_if.ready)
                sb.check_reading('{humidity: out_if.humidity, count_zero: out_if.count_zero});
        end
    end

    // Watchdog. The slowest correct run, with long gaps on both sides for every
    // beat, stays well under this limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Output ready. Random stalls of mixed length are interleaved with
    // occasional long stretches of uninterrupted ready. Over many beats, stalls
    // therefore land at every depth of the pipeline.
    initial begin
        int run;
        int gap;
        out_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                              : $urandom_range(1, 30);
            out_if.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_idle();
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        // The directed counts come first. They cover the zero count and both
        // sides of the low-count cutoff. They also cover the full-scale count
        // and alternating bit patterns. The rest are points around x = 0.5,
        // 0.6, 0.7, 0.8, 0.9, 1.0, 1.3, 1.5, 2 and 3, which cover the places where
        // the cubic crosses its clamp limits.
        t_count directed [] = '{
            t_count'(0),     t_count'(1),     t_count'(1553),  t_count'(1554),
            t_count'(1555),  t_count'(65535), t_count'(65534), t_count'(16'h8000),
            t_count'(16'h5555), t_count'(16'hAAAA), t_count'(6216), t_count'(6907),
            t_count'(5800),  t_count'(4144),  t_count'(4781),  t_count'(10360),
            t_count'(9000),  t_count'(8880),  t_count'(7770),  t_count'(12432),
            t_count'(2072),  t_count'(3108),  t_count'(0)
        };
        logic burst;

        sb                = new();
        cycles            = 0;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.pulse_count <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_count(directed[i], pick_idle());

        // Every hundred beats, the sender picks between random gaps and a
        // gap-free burst, so the pipeline also runs at full rate.
        burst = 1'b0;
        for (int n = 0; n < RANDOM_COUNTS; n++) begin
            if (n % 100 == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_count(pick_count(), burst ? 0 : pick_idle());
        end
        in_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/chfr_pkg.sv
design/chfr_in_if.sv
design/chfr_out_if.sv
design/chfr_div.sv
design/chfr_mul.sv
design/chfr_poly.sv
design/capacitive_humidity_freq_to_rh_core.sv
bench/tb_top.sv
